>>> rtl/lbcts_pkg.sv
// Shared types and constants of the LRU block cache tag store.
package lbcts_pkg;
  localparam int WaysDef = 16;
  localparam int FileIdBitsDef = 10;
  localparam int BlockNumBitsDef = 32;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_CLOSE = 2'd2;
  localparam logic [1:0] FUNC_FLUSH = 2'd3;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic retag;    // selected cell loads new tag
    logic set_dirty;
    logic clr_dirty;
    logic invalidate;
    logic touch;    // update recency ranks against the selected cell
  } lbcts_cmd_t;
endpackage

>>> rtl/lbcts_cell.sv
// One way of the tag store: tag, flags, recency rank and local match logic.
module lbcts_cell
  import lbcts_pkg::*;
#(
  parameter int WAYS = WaysDef,
  parameter int FILE_ID_BITS = FileIdBitsDef,
  parameter int BLOCK_NUM_BITS = BlockNumBitsDef,
  parameter int IDX = 0,
  localparam int RW = $clog2(WAYS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [FILE_ID_BITS-1:0]   key_file,
  input  logic [BLOCK_NUM_BITS-1:0] key_block,
  input  lbcts_cmd_t                cmd,
  input  logic                      sel,
  input  logic [RW-1:0]             sel_rank,
  output logic                      valid,
  output logic                      dirty,
  output logic                      hit,
  output logic                      file_match,
  output logic [RW-1:0]             rank,
  output logic [FILE_ID_BITS-1:0]   tag_file,
  output logic [BLOCK_NUM_BITS-1:0] tag_block
);
  logic valid_r, dirty_r;
  logic [RW-1:0] rank_r;
  logic [FILE_ID_BITS-1:0] file_r;
  logic [BLOCK_NUM_BITS-1:0] block_r;

  assign file_match = valid_r && (file_r == key_file);
  assign hit = file_match && (block_r == key_block);
  assign valid = valid_r;
  assign dirty = dirty_r;
  assign rank = rank_r;
  assign tag_file = file_r;
  assign tag_block = block_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      rank_r <= RW'(IDX);
    end else begin
      if (cmd.touch) begin
        if (sel) rank_r <= '0;
        else if (rank_r < sel_rank) rank_r <= rank_r + RW'(1);
      end
      if (sel) begin
        if (cmd.retag) begin
          valid_r <= 1'b1;
          dirty_r <= 1'b0;
        end
        if (cmd.clr_dirty) dirty_r <= 1'b0;
        if (cmd.set_dirty) dirty_r <= 1'b1;
        if (cmd.invalidate) valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.retag) begin
      file_r <= key_file;
      block_r <= key_block;
    end
  end
endmodule

>>> rtl/lru_block_cache_tag_store.sv
// Top level of the LRU block cache tag store: cell row plus request sequencer.
// A row of WAYS cells each holds one way's tags, valid and dirty flags and its
// recency rank (0 = most recent). For a read or write, the accept edge
// registers the request, and in the next cycle every cell compares its tag in
// parallel while the sequencer picks the hit, the lowest invalid way or the
// way of rank WAYS-1; that edge updates the cell state and loads the result
// beat, which is valid from the following cycle. Close and flush register the
// request, walk the cells one way per cycle, then load the closing beat, and
// give one write-back beat per dirty way of the file, ascending, then a closing
// beat with last set. A beat that is not taken holds the sequencer: an access
// waits with its decision, and a walk stops at the next dirty way of the file
// until the output register frees. One request is in flight at a time; the
// output register lets the next request be accepted while a final beat still
// waits to be taken.
module lru_block_cache_tag_store
  import lbcts_pkg::*;
#(
  parameter int WAYS = WaysDef,
  parameter int FILE_ID_BITS = FileIdBitsDef,
  parameter int BLOCK_NUM_BITS = BlockNumBitsDef,
  localparam int RW = $clog2(WAYS),
  localparam int IW = 2 + FILE_ID_BITS + BLOCK_NUM_BITS,
  localparam int IDW = ((IW + 7) / 8) * 8,
  localparam int OW = 2 + RW + FILE_ID_BITS + BLOCK_NUM_BITS,
  localparam int ODW = ((OW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  // func, file_id, block_number (low to high)
  input  logic [IDW-1:0] in_tdata,
  output logic           out_tvalid,
  input  logic           out_tready,
  // hit, way, writeback, victim_file, victim_block (low to high)
  output logic [ODW-1:0] out_tdata,
  output logic           out_tlast
);
  typedef enum logic [1:0] {S_IDLE, S_ACCESS, S_WALK, S_CLOSE} state_t;

  state_t state_r;
  logic [1:0] func_r;
  logic [FILE_ID_BITS-1:0] file_r;
  logic [BLOCK_NUM_BITS-1:0] block_r;
  logic [RW-1:0] ptr_r;
  logic ovalid_r, olast_r;
  logic [OW-1:0] odata_r;

  lbcts_cmd_t cmd;
  logic [WAYS-1:0] sel, c_valid, c_dirty, c_hit, c_fm;
  logic [RW-1:0] c_rank [WAYS];
  logic [FILE_ID_BITS-1:0] c_file [WAYS];
  logic [BLOCK_NUM_BITS-1:0] c_block [WAYS];
  logic [RW-1:0] sel_rank;

  for (genvar g = 0; g < WAYS; g++) begin : g_cell
    lbcts_cell #(
      .WAYS(WAYS), .FILE_ID_BITS(FILE_ID_BITS),
      .BLOCK_NUM_BITS(BLOCK_NUM_BITS), .IDX(g)
    ) u_cell (
      .clk, .rst_n, .key_file(file_r), .key_block(block_r), .cmd,
      .sel(sel[g]), .sel_rank, .valid(c_valid[g]), .dirty(c_dirty[g]),
      .hit(c_hit[g]), .file_match(c_fm[g]), .rank(c_rank[g]),
      .tag_file(c_file[g]), .tag_block(c_block[g])
    );
  end

  // Choose the way for an access: hit, else lowest invalid, else LRU.
  logic any_hit, any_inv, any_lru;
  logic [RW-1:0] hit_w, inv_w, lru_w, acc_w;
  always_comb begin
    any_hit = 1'b0; any_inv = 1'b0; any_lru = 1'b0;
    hit_w = '0; inv_w = '0; lru_w = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (c_hit[i]) begin any_hit = 1'b1; hit_w = RW'(i); end
      if (!c_valid[i]) begin any_inv = 1'b1; inv_w = RW'(i); end
      if (c_rank[i] == RW'(WAYS - 1)) begin any_lru = 1'b1; lru_w = RW'(i); end
    end
    acc_w = any_hit ? hit_w : (any_inv ? inv_w : lru_w);
  end

  logic out_free;
  assign out_free = !ovalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  logic walk_emit;
  assign walk_emit = c_fm[ptr_r] && c_dirty[ptr_r];

  // Load a new beat into the output register this cycle.
  logic oload;
  always_comb begin
    case (state_r)
      S_ACCESS, S_CLOSE: oload = out_free;
      S_WALK: oload = out_free && walk_emit;
      default: oload = 1'b0;
    endcase
  end

  always_comb begin
    cmd = '0;
    sel = '0;
    sel_rank = '0;
    case (state_r)
      S_ACCESS: if (out_free) begin
        sel[acc_w] = 1'b1;
        sel_rank = c_rank[acc_w];
        cmd.retag = !any_hit;
        cmd.set_dirty = (func_r == FUNC_WRITE);
        cmd.touch = 1'b1;
      end
      S_WALK: if (out_free || !walk_emit) begin
        sel[ptr_r] = c_fm[ptr_r];
        cmd.clr_dirty = 1'b1;
        cmd.invalidate = (func_r == FUNC_CLOSE);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
      ptr_r <= '0;
    end else begin
      if (oload) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          func_r <= in_tdata[1:0];
          file_r <= in_tdata[2 +: FILE_ID_BITS];
          block_r <= in_tdata[2 + FILE_ID_BITS +: BLOCK_NUM_BITS];
          ptr_r <= '0;
          state_r <= (in_tdata[1:0] == FUNC_READ || in_tdata[1:0] == FUNC_WRITE)
                     ? S_ACCESS : S_WALK;
        end
        S_ACCESS: if (out_free) begin
          olast_r <= 1'b1;
          odata_r <= {(any_hit || any_inv || !c_dirty[acc_w]) ? BLOCK_NUM_BITS'(0)
                        : c_block[acc_w],
                      (any_hit || any_inv || !c_dirty[acc_w]) ? FILE_ID_BITS'(0)
                        : c_file[acc_w],
                      !any_hit && !any_inv && c_dirty[acc_w], acc_w, any_hit};
          state_r <= S_IDLE;
        end
        S_WALK: if (out_free || !walk_emit) begin
          if (walk_emit) begin
            olast_r <= 1'b0;
            odata_r <= {c_block[ptr_r], c_file[ptr_r], 1'b1, ptr_r, 1'b0};
          end
          if (ptr_r == RW'(WAYS - 1)) state_r <= S_CLOSE;
          else ptr_r <= ptr_r + RW'(1);
        end
        S_CLOSE: if (out_free) begin
          olast_r <= 1'b1;
          odata_r <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tlast = olast_r;
  assign out_tdata = ODW'(odata_r);

`ifndef SYNTHESIS
  a_one_sel: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel)) else $error("more than one cell selected");
  a_lru_exists: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACCESS |-> any_lru) else $error("no way holds the LRU rank");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat dropped");
`endif
endmodule

>>> tb/sv/lru_block_cache_tag_store_checker.sv
// Checker for the LRU block cache tag store: predicts and compares result beats.
`timescale 1ns / 1ps
module lru_block_cache_tag_store_checker
  import lbcts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [47:0] in_tdata,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [47:0] out_tdata,
  input  logic       out_tlast,
  output int         fail_count,
  output int         pending_count,
  output int         beat_count
);
  localparam int NWAYS = 16;

  typedef struct packed {
    logic        hit;
    logic [3:0]  way;
    logic        writeback;
    logic [9:0]  vfile;
    logic [31:0] vblock;
    logic        last;
  } cache_beat_t;

  logic        way_valid [NWAYS];
  logic        way_dirty [NWAYS];
  logic [9:0]  way_file  [NWAYS];
  logic [31:0] way_block [NWAYS];
  logic [3:0]  way_rank  [NWAYS];
  cache_beat_t expected_beats[$];

  // Move way w to rank 0, aging every way that was more recent.
  function automatic void promote(int w);
    logic [3:0] old;
    old = way_rank[w];
    for (int i = 0; i < NWAYS; i++)
      if (way_rank[i] < old) way_rank[i]++;
    way_rank[w] = '0;
  endfunction

  task automatic predict_request(logic [1:0] func, logic [9:0] fid, logic [31:0] blk);
    cache_beat_t b;
    int w;
    logic found;
    found = 1'b0;
    w = 0;
    b = '0;
    if (func == FUNC_READ || func == FUNC_WRITE) begin
      for (int i = 0; i < NWAYS; i++)
        if (!found && way_valid[i] && way_file[i] == fid && way_block[i] == blk) begin
          found = 1'b1;
          w = i;
        end
      if (!found) begin
        // Lowest invalid way first, else the least recently used one.
        w = -1;
        for (int i = NWAYS - 1; i >= 0; i--)
          if (!way_valid[i]) w = i;
        if (w < 0) begin
          w = 0;
          for (int i = 1; i < NWAYS; i++)
            if (way_rank[i] > way_rank[w]) w = i;
        end
        if (way_valid[w] && way_dirty[w]) begin
          b.writeback = 1'b1;
          b.vfile = way_file[w];
          b.vblock = way_block[w];
        end
        way_valid[w] = 1'b1;
        way_file[w] = fid;
        way_block[w] = blk;
        way_dirty[w] = 1'b0;
      end
      if (func == FUNC_WRITE) way_dirty[w] = 1'b1;
      promote(w);
      b.hit = found;
      b.way = w[3:0];
      b.last = 1'b1;
      expected_beats.push_back(b);
    end else begin
      for (int i = 0; i < NWAYS; i++) begin
        if (way_valid[i] && way_file[i] == fid) begin
          if (way_dirty[i]) begin
            b = '0;
            b.way = i[3:0];
            b.writeback = 1'b1;
            b.vfile = way_file[i];
            b.vblock = way_block[i];
            expected_beats.push_back(b);
            way_dirty[i] = 1'b0;
          end
          if (func == FUNC_CLOSE) way_valid[i] = 1'b0;
        end
      end
      b = '0;
      b.last = 1'b1;
      expected_beats.push_back(b);
    end
  endtask

  always @(posedge clk) begin
    cache_beat_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < NWAYS; i++) begin
        way_valid[i] <= 1'b0;
        way_dirty[i] <= 1'b0;
        way_file[i] <= '0;
        way_block[i] <= '0;
        way_rank[i] <= i[3:0];
      end
      expected_beats.delete();
      fail_count <= 0;
      beat_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[4:1], out_tdata[5], out_tdata[15:6],
               out_tdata[47:16], out_tlast};
        beat_count <= beat_count + 1;
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_beats.pop_front();
          if (got != want) begin
            if (got.hit != want.hit) $error("hit exp %0d got %0d", want.hit, got.hit);
            if (got.way != want.way) $error("way exp %0d got %0d", want.way, got.way);
            if (got.writeback != want.writeback)
              $error("writeback exp %0d got %0d", want.writeback, got.writeback);
            if (got.vfile != want.vfile)
              $error("victim_file exp %0d got %0d", want.vfile, got.vfile);
            if (got.vblock != want.vblock)
              $error("victim_block exp %h got %h", want.vblock, got.vblock);
            if (got.last != want.last) $error("last exp %0d got %0d", want.last, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        predict_request(in_tdata[1:0], in_tdata[11:2], in_tdata[43:12]);
    end
    pending_count <= expected_beats.size();
  end
endmodule

>>> tb/sv/lru_block_cache_tag_store_test.sv
// Testbench top for the LRU block cache tag store: stimulus, idling and verdict.
`timescale 1ns / 1ps
module lru_block_cache_tag_store_test;
  import lbcts_pkg::*;

  localparam int LIMIT = 1000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // func, file_id, block_number, zero pad (low to high)
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [47:0] out_tdata;       // hit, way, writeback, victim_file, victim_block (low to high)
  logic        out_tlast;
  int          fail_count, pending_count, beat_count;
  int          cycle_count = 0;
  int          request_count = 0;
  logic        no_gaps = 0;     // stretches with no idling on either side

  always #10 clk = ~clk;

  lru_block_cache_tag_store u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

  lru_block_cache_tag_store_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .fail_count, .pending_count, .beat_count
  );

  // Give up on a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: hold tready low for a random stall, then take one beat.
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 15);
      repeat (stall) @(posedge clk);
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
      if (!no_gaps) out_tready <= 1'b0;
    end
  end

  // Send one request beat after a random gap; hold tvalid high between
  // back-to-back beats so it is never dropped and raised in one step.
  task automatic send(logic [1:0] func, logic [9:0] fid, logic [31:0] blk);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, blk, fid, func};
    @(posedge clk iff in_tready);
    request_count++;
  endtask

  initial begin
    logic [9:0]  fid;
    logic [31:0] blk;
    logic [1:0]  func;
    int          r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty close and flush, field extremes, fill all 16 ways
    // with dirty and clean lines, then hits, flush and close.
    send(FUNC_CLOSE, 10'd5, 32'd0);
    send(FUNC_FLUSH, 10'd5, 32'd0);
    send(FUNC_WRITE, 10'h3FF, 32'hFFFF_FFFF);
    send(FUNC_READ,  10'h000, 32'h0000_0000);
    send(FUNC_WRITE, 10'h3FF, 32'hFFFF_FFFF);
    send(FUNC_READ,  10'h2AA, 32'hAAAA_AAAA);
    send(FUNC_WRITE, 10'h155, 32'h5555_5555);
    for (int i = 0; i < 12; i++) send(FUNC_WRITE, 10'd7, 32'(i));
    send(FUNC_READ,  10'd7, 32'd3);
    send(FUNC_FLUSH, 10'd7, 32'd0);
    send(FUNC_FLUSH, 10'h3FF, 32'd0);
    send(FUNC_CLOSE, 10'd7, 32'hFFFF_FFFF);
    send(FUNC_CLOSE, 10'h3FF, 32'd0);

    // Random: mostly a small working set so hits, evictions and write-backs
    // repeat; some wide-range noise to toggle every bit.
    for (int n = 0; n < 360; n++) begin
      if (n % 90 == 60) no_gaps = 1'b1;
      if (n % 90 == 80) no_gaps = 1'b0;
      r = $urandom_range(0, 99);
      func = (r < 40) ? FUNC_READ : (r < 80) ? FUNC_WRITE : (r < 90) ? FUNC_FLUSH : FUNC_CLOSE;
      if ($urandom_range(0, 9) == 0) begin
        fid = 10'($urandom);
        blk = $urandom;
      end else begin
        fid = 10'($urandom_range(0, 3));
        blk = $urandom_range(0, 9);
      end
      send(func, fid, blk);
    end
    in_tvalid <= 1'b0;
    no_gaps = 1'b0;

    wait (pending_count == 0);
    repeat (40) @(posedge clk);
    $display("sent %0d requests (read, write, flush, close), checked %0d result beats",
             request_count, beat_count);
    if (fail_count == 0 && pending_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
